FILE: rtl/sht_pkg.sv
// Package for the tile slope height pipeline.
// Slope codes, rule kinds and height constants; no dependencies.
package sht_pkg;

   localparam int unsigned COORD_W  = 4;
   localparam int unsigned CODE_W   = 5;
   localparam int unsigned HEIGHT_W = 5;

   localparam logic [COORD_W-1:0]  MIRROR_MASK = 4'hF;
   localparam logic [HEIGHT_W-1:0] PLATEAU     = 5'd8;
   localparam logic [HEIGHT_W-1:0] FLAT_LEVEL  = 5'd4;

   localparam logic [CODE_W-1:0] SLOPE_W        = 5'd1;
   localparam logic [CODE_W-1:0] SLOPE_S        = 5'd2;
   localparam logic [CODE_W-1:0] SLOPE_SW       = 5'd3;
   localparam logic [CODE_W-1:0] SLOPE_E        = 5'd4;
   localparam logic [CODE_W-1:0] SLOPE_EW       = 5'd5;
   localparam logic [CODE_W-1:0] SLOPE_SE       = 5'd6;
   localparam logic [CODE_W-1:0] SLOPE_WSE      = 5'd7;
   localparam logic [CODE_W-1:0] SLOPE_N        = 5'd8;
   localparam logic [CODE_W-1:0] SLOPE_NW       = 5'd9;
   localparam logic [CODE_W-1:0] SLOPE_NS       = 5'd10;
   localparam logic [CODE_W-1:0] SLOPE_NWS      = 5'd11;
   localparam logic [CODE_W-1:0] SLOPE_NE       = 5'd12;
   localparam logic [CODE_W-1:0] SLOPE_ENW      = 5'd13;
   localparam logic [CODE_W-1:0] SLOPE_SEN      = 5'd14;
   localparam logic [CODE_W-1:0] SLOPE_ELEV     = 5'd15;
   localparam logic [CODE_W-1:0] SLOPE_STEEP_S  = 5'd23;
   localparam logic [CODE_W-1:0] SLOPE_STEEP_W  = 5'd27;
   localparam logic [CODE_W-1:0] SLOPE_STEEP_N  = 5'd29;
   localparam logic [CODE_W-1:0] SLOPE_STEEP_E  = 5'd30;

   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_FLAT,
      KIND_RISE,
      KIND_FALL,
      KIND_HALF,
      KIND_HALF_INC
   } kind_type;

endpackage

FILE: rtl/slope_height_in_tile.sv
// Tile slope height: three-stage pipeline from point and slope code to height.
// Depends on sht_pkg.
//
// Usage: the request channel (req_valid, req_stall, req_pos_x, req_pos_y,
// req_corner_code) carries one point of a 16 by 16 tile and its slope code.
// The response channel (rsp_valid, rsp_stall, rsp_height) returns the
// terrain height of that point, 0 to 16, one word per request, in order.
// Stage 1 decodes the slope code into a rule and two operands, stage 2
// forms their sum and difference, stage 3 applies the rule and holds the
// result in the output register. rsp_valid rises once the word has moved
// from the stage 1 register through stage 2 into stage 3, and the word
// leaves on an edge with rsp_stall low; one word is taken every cycle while rsp_stall is low.
// Each stage loads whenever it is empty or its successor moves, so
// bubbles are squeezed out under stall and no word is lost or repeated.
// req_stall rises only when all three stages hold words and the receiver
// stalls. Synchronous reset empties the pipeline; payload registers are
// not reset.
module slope_height_in_tile (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sht_pkg::COORD_W-1:0]   req_pos_x,
   input  logic [sht_pkg::COORD_W-1:0]   req_pos_y,
   input  logic [sht_pkg::CODE_W-1:0]    req_corner_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sht_pkg::HEIGHT_W-1:0]  rsp_height
);
   import sht_pkg::*;

   logic                en1, en2, en3;
   logic                v1_ff, v2_ff, v3_ff;

   kind_type            kind1_in, kind1_ff, kind2_ff;
   logic [COORD_W-1:0]  a1_in, b1_in, a1_ff, b1_ff;
   logic [COORD_W-1:0]  mx, my;

   logic [COORD_W:0]    diff2_in, sum2_in, diff2_ff, sum2_ff;
   logic                neg2_in, neg2_ff;

   logic [HEIGHT_W-1:0] height3_in, height3_ff;
   logic [COORD_W:0]    fall_half;

   assign en3       = !v3_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;
   assign rsp_valid = v3_ff;
   assign rsp_height = height3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // stage 1: rule decode
   assign mx = req_pos_x ^ MIRROR_MASK;
   assign my = req_pos_y ^ MIRROR_MASK;

   always_comb begin
      kind1_in = KIND_ZERO;
      a1_in    = '0;
      b1_in    = '0;
      unique case (req_corner_code) inside
         SLOPE_W: begin
            kind1_in = KIND_RISE; a1_in = req_pos_x; b1_in = req_pos_y;
         end
         SLOPE_S: begin
            kind1_in = KIND_RISE; a1_in = req_pos_x; b1_in = my;
         end
         SLOPE_SW: begin
            kind1_in = KIND_HALF_INC; a1_in = req_pos_x;
         end
         SLOPE_E: begin
            kind1_in = KIND_RISE; a1_in = req_pos_y; b1_in = req_pos_x;
         end
         SLOPE_EW, SLOPE_NS, SLOPE_ELEV: begin
            kind1_in = KIND_FLAT;
         end
         SLOPE_SE: begin
            kind1_in = KIND_HALF_INC; a1_in = req_pos_y;
         end
         SLOPE_WSE: begin
            kind1_in = KIND_FALL; a1_in = req_pos_x; b1_in = my;
         end
         SLOPE_N: begin
            kind1_in = KIND_RISE; a1_in = my; b1_in = req_pos_x;
         end
         SLOPE_NW: begin
            kind1_in = KIND_HALF; a1_in = my;
         end
         SLOPE_NWS: begin
            kind1_in = KIND_FALL; a1_in = req_pos_x; b1_in = req_pos_y;
         end
         SLOPE_NE: begin
            kind1_in = KIND_HALF; a1_in = mx;
         end
         SLOPE_ENW: begin
            kind1_in = KIND_FALL; a1_in = my; b1_in = req_pos_x;
         end
         SLOPE_SEN: begin
            kind1_in = KIND_FALL; a1_in = req_pos_y; b1_in = req_pos_x;
         end
         SLOPE_STEEP_S: begin
            kind1_in = KIND_HALF_INC; a1_in = req_pos_x; b1_in = req_pos_y;
         end
         SLOPE_STEEP_W: begin
            kind1_in = KIND_HALF_INC; a1_in = req_pos_x; b1_in = my;
         end
         SLOPE_STEEP_N, SLOPE_STEEP_E: begin
            kind1_in = KIND_HALF_INC; a1_in = mx; b1_in = my;
         end
         default: begin
            kind1_in = KIND_ZERO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         kind1_ff <= kind1_in;
         a1_ff    <= a1_in;
         b1_ff    <= b1_in;
      end
   end

   // stage 2: sum and difference
   assign diff2_in = {1'b0, a1_ff} - {1'b0, b1_ff};
   assign sum2_in  = {1'b0, a1_ff} + {1'b0, b1_ff};
   assign neg2_in  = a1_ff < b1_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         kind2_ff <= kind1_ff;
         diff2_ff <= diff2_in;
         sum2_ff  <= sum2_in;
         neg2_ff  <= neg2_in;
      end
   end

   // stage 3: rule finish, floor of a negative half difference
   assign fall_half = {diff2_ff[COORD_W], diff2_ff[COORD_W:1]};

   always_comb begin
      case (kind2_ff)
         KIND_FLAT:     height3_in = FLAT_LEVEL;
         KIND_RISE:     height3_in = neg2_ff ? '0 : {1'b0, diff2_ff[COORD_W:1]};
         KIND_FALL:     height3_in = neg2_ff ? PLATEAU + fall_half : PLATEAU;
         KIND_HALF:     height3_in = {1'b0, sum2_ff[COORD_W:1]};
         KIND_HALF_INC: height3_in = {1'b0, sum2_ff[COORD_W:1]} + 5'd1;
         default:       height3_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en3) height3_ff <= height3_in;
   end

endmodule
